// File: design/diff_drive_imu_odometry_top_assert.svh
// Assertion macros for the odometry block checker.
// Needs clk and rst_n in the scope where the macros are used.
`ifndef DIFF_DRIVE_IMU_ODOMETRY_TOP_ASSERT_SVH
`define DIFF_DRIVE_IMU_ODOMETRY_TOP_ASSERT_SVH

// antecedent now, consequent on the next clock
`define DDIO_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ddio check failed");

// antecedent and consequent on the same clock
`define DDIO_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ddio check failed");

`endif

// File: design/ddio_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the odometry block.
// No dependencies.
package ddio_pkg;

    // default parameter values
    localparam int ANGLE_BITS_DEF    = 16;
    localparam int POS_BITS_DEF      = 48;
    localparam int CORDIC_STAGES_DEF = 16;

    // field widths
    localparam int YAW_W     = 12;
    localparam int RATE_W    = 16;
    localparam int EL_W      = 20;
    localparam int DPC_W     = 24;
    localparam int OUT_POS_W = 48;
    localparam int OUT_ANG_W = 16;

    localparam logic [DPC_W-1:0] DPC_RESET   = 24'd28147;
    localparam logic [EL_W-1:0]  ELAPSED_MAX = 20'd1000000;

    // tenths of a degree per turn, and half of it for rounding
    localparam logic [YAW_W-1:0] YAW_DIV  = 12'd3600;
    localparam logic [YAW_W-1:0] YAW_HALF = 12'd1800;

    // CORDIC datapath
    localparam int CW_W = 34;
    localparam logic signed [CW_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam int ATAN_N = 24;
    localparam logic [31:0] ATAN_TURN [ATAN_N] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_YAW,
        ST_ROT,
        ST_POS,
        ST_WB
    } state_t;

endpackage

// File: design/ddio_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for sensor frames and odometry results.
// Depends on nothing.
interface ddio_frame_if;
    logic               valid;
    logic               ready;
    logic [11:0]        yaw_tenths;
    logic signed [15:0] left_rate;
    logic signed [15:0] right_rate;
    logic [19:0]        elapsed_us;

    modport source (output valid, yaw_tenths, left_rate, right_rate, elapsed_us,
                    input ready);
    modport sink   (input valid, yaw_tenths, left_rate, right_rate, elapsed_us,
                    output ready);
endinterface

interface ddio_result_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] left_distance;
    logic signed [47:0] right_distance;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic signed [47:0] x_position;
    logic signed [47:0] y_position;
    logic [15:0]        heading;
    logic [15:0]        yaw_angle;

    modport source (output valid, left_distance, right_distance, left_speed,
                    right_speed, x_position, y_position, heading, yaw_angle,
                    input ready);
    modport sink   (input valid, left_distance, right_distance, left_speed,
                    right_speed, x_position, y_position, heading, yaw_angle,
                    output ready);
endinterface

// File: design/ddio_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider: yaw tenths to a binary angle, round half up.
// Depends on ddio_pkg.
module ddio_div #(
    parameter int ANGLE_BITS = ddio_pkg::ANGLE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [11:0]           yaw_tenths,
    output logic                  done,
    output logic [ANGLE_BITS-1:0] yaw
);
    localparam int NW = ddio_pkg::YAW_W + ANGLE_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] num_reg;
    logic [11:0]   rem_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [12:0] rem_sh;
    logic        ge;
    logic [11:0] rem_next;
    logic        last;

    // one quotient bit per cycle
    always_comb
    begin
        rem_sh   = {rem_reg, num_reg[NW-1]};
        ge       = rem_sh >= {1'b0, ddio_pkg::YAW_DIV};
        rem_next = ge ? 12'(rem_sh - {1'b0, ddio_pkg::YAW_DIV}) : rem_sh[11:0];
        last     = cnt_reg == CW'(NW - 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                    busy_reg <= 1'b0;
            end
        end
    end

    // numerator shifts out at the top, quotient bits shift in at the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= {yaw_tenths, ANGLE_BITS'(0)} + NW'(ddio_pkg::YAW_HALF);
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NW-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign yaw  = num_reg[ANGLE_BITS-1:0];
endmodule

// File: design/ddio_mul.sv
`timescale 1ns / 1ps
// Bit-serial signed multiplier, one multiplier bit per cycle, LSB first.
// Depends on nothing.
module ddio_mul #(
    parameter int AW = 16,
    parameter int BW = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic                    done,
    output logic signed [AW+BW-1:0] p
);
    localparam int PW = AW + BW;
    localparam int CW = $clog2(BW + 1);

    logic signed [PW-1:0] a_reg;
    logic signed [PW-1:0] acc_reg;
    logic [BW-1:0]        b_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic                 last;

    assign last = cnt_reg == CW'(BW - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                    busy_reg <= 1'b0;
            end
        end
    end

    // sign bit of the multiplier carries negative weight
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= PW'(a);
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
                acc_reg <= last ? acc_reg - a_reg : acc_reg + a_reg;
            a_reg <= a_reg <<< 1;
            b_reg <= b_reg >> 1;
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;
endmodule

// File: design/ddio_cordic.sv
`timescale 1ns / 1ps
// Iterative CORDIC, one rotation stage per cycle, cos and sin in Q30.
// Depends on ddio_pkg.
module ddio_cordic #(
    parameter int CORDIC_STAGES = ddio_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [31:0]                         angle,
    output logic                                done,
    output logic signed [ddio_pkg::CW_W-1:0]    cos_q,
    output logic signed [ddio_pkg::CW_W-1:0]    sin_q
);
    localparam int IW = $clog2(ddio_pkg::ATAN_N);

    logic signed [ddio_pkg::CW_W-1:0] x_reg, y_reg, z_reg;
    logic                             flip_reg;
    logic [IW-1:0]                    cnt_reg;
    logic                             busy_reg;
    logic                             done_reg;

    logic                             last;
    logic                             flip;
    logic [31:0]                      ang_f;
    logic signed [ddio_pkg::CW_W-1:0] at, xs, ys;

    always_comb
    begin
        last  = cnt_reg == IW'(CORDIC_STAGES - 1);
        // fold the left half plane onto the right one
        flip  = angle[31] ^ angle[30];
        ang_f = {angle[31] ^ flip, angle[30:0]};
        at    = $signed({2'b00, ddio_pkg::ATAN_TURN[cnt_reg]});
        xs    = x_reg >>> cnt_reg;
        ys    = y_reg >>> cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                    busy_reg <= 1'b0;
            end
        end
    end

    // rotation datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= ddio_pkg::CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= ddio_pkg::CW_W'($signed(ang_f));
            flip_reg <= flip;
        end
        else if (busy_reg)
        begin
            if (!z_reg[ddio_pkg::CW_W-1])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
    end

    assign done  = done_reg;
    assign cos_q = flip_reg ? -x_reg : x_reg;
    assign sin_q = flip_reg ? -y_reg : y_reg;
endmodule

// File: design/diff_drive_imu_odometry_top.sv
`timescale 1ns / 1ps
// Channel     Dir  Handshake     Payload
// frame       in   valid/ready   yaw_tenths, left_rate, right_rate, elapsed_us
// result      out  valid/ready   distances, speeds, x/y position, heading, yaw
// cfg         in   cfg_we        cfg_wdata = distance per count per microsecond
//
// One item at a time. The yaw divider runs first, then CORDIC and the wheel multipliers
// run side by side, then the position multipliers run, and the result is written to the
// output register once that is free. A first frame after reset runs only the divider
// and gives no result. frame.ready is high only while idle; a pending result waits in
// the output register, and the next item is taken meanwhile. Reset clears the odometry
// state, except that the heading starts at a quarter turn and the distance per count
// starts at its default value.
// Depends on ddio_pkg, ddio_ifs, ddio_div, ddio_mul, ddio_cordic.
module diff_drive_imu_odometry_top #(
    parameter int ANGLE_BITS    = ddio_pkg::ANGLE_BITS_DEF,
    parameter int POS_BITS      = ddio_pkg::POS_BITS_DEF,
    parameter int CORDIC_STAGES = ddio_pkg::CORDIC_STAGES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [23:0] cfg_wdata,
    ddio_frame_if.sink    frame,
    ddio_result_if.source result
);
    localparam int M1W = 46;
    localparam int M2W = M1W + 17;
    localparam int DW  = 30;
    localparam int M3W = ddio_pkg::CW_W + DW;

    ddio_pkg::state_t state_reg, state_next;

    logic                  first_reg;
    logic [23:0]           dpc_reg;
    logic signed [15:0]    lr_reg, rr_reg;
    logic signed [15:0]    last_l_reg, last_r_reg;
    logic [ANGLE_BITS-1:0] last_yaw_reg;
    logic [ANGLE_BITS-1:0] heading_reg;
    logic [POS_BITS-1:0]   left_acc_reg, right_acc_reg, x_acc_reg, y_acc_reg;
    logic                  c_seen_reg, m_seen_reg;

    logic               out_valid_reg;
    logic signed [47:0] o_ld_reg, o_rd_reg, o_x_reg, o_y_reg;
    logic signed [15:0] o_ls_reg, o_rs_reg;
    logic [15:0]        o_hd_reg, o_yaw_reg;

    logic accept, start1, start2, start3, first_done, commit;

    // serial units
    logic                  div_done;
    logic [ANGLE_BITS-1:0] yaw_div;
    logic                  m1_done, ml_done, mr_done, mx_done, my_done, c_done;
    logic signed [M1W-1:0] m1_p;
    logic signed [M2W-1:0] pl, pr;
    logic signed [M3W-1:0] px, py;
    logic signed [ddio_pkg::CW_W-1:0] cos_q, sin_q;

    logic [19:0]           el_c;
    logic signed [16:0]    sum_l, sum_r;
    logic [ANGLE_BITS-1:0] dd, mid, heading_new;
    logic [31:0]           mid32, hd32, yaw32;
    logic signed [63:0]    psum, rl, rr_step, rx, ry, dfull;
    logic signed [DW-1:0]  d;
    logic [POS_BITS-1:0]   left_new, right_new, x_new, y_new;
    logic signed [63:0]    ext_l, ext_r, ext_x, ext_y;

    assign accept = frame.valid && frame.ready;

    // datapath glue
    always_comb
    begin
        el_c  = (frame.elapsed_us > ddio_pkg::ELAPSED_MAX) ? ddio_pkg::ELAPSED_MAX
                                                           : frame.elapsed_us;
        sum_l = 17'(lr_reg) + 17'(last_l_reg);
        sum_r = 17'(rr_reg) + 17'(last_r_reg);
        // heading step wrapped to half a turn, mid-step heading
        dd          = last_yaw_reg - yaw_div;
        mid         = heading_reg + ANGLE_BITS'($signed(dd) >>> 1);
        heading_new = heading_reg + dd;
        mid32       = 32'(mid) << (32 - ANGLE_BITS);
        // path step with rounding
        psum  = 64'(pl) + 64'(pr);
        dfull = (psum + 64'sd8589934592) >>> 34;
        d     = dfull[DW-1:0];
        rl      = (64'(pl) + 64'sd4294967296) >>> 33;
        rr_step = (64'(pr) + 64'sd4294967296) >>> 33;
        rx      = (64'(px) + 64'sd536870912) >>> 30;
        ry      = (64'(py) + 64'sd536870912) >>> 30;
        left_new  = left_acc_reg + rl[POS_BITS-1:0];
        right_new = right_acc_reg + rr_step[POS_BITS-1:0];
        x_new     = x_acc_reg + rx[POS_BITS-1:0];
        y_new     = y_acc_reg + ry[POS_BITS-1:0];
        ext_l = 64'($signed(left_new));
        ext_r = 64'($signed(right_new));
        ext_x = 64'($signed(x_new));
        ext_y = 64'($signed(y_new));
        hd32  = 32'(heading_new) << (32 - ANGLE_BITS);
        yaw32 = 32'(yaw_div) << (32 - ANGLE_BITS);
    end

    ddio_div #(.ANGLE_BITS(ANGLE_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(start1), .yaw_tenths(frame.yaw_tenths),
        .done(div_done), .yaw(yaw_div)
    );

    ddio_mul #(.AW(25), .BW(21)) u_mul_tick (
        .clk(clk), .rst_n(rst_n), .start(start1),
        .a($signed({1'b0, dpc_reg})), .b($signed({1'b0, el_c})),
        .done(m1_done), .p(m1_p)
    );

    ddio_mul #(.AW(M1W), .BW(17)) u_mul_left (
        .clk(clk), .rst_n(rst_n), .start(start2), .a(m1_p), .b(sum_l),
        .done(ml_done), .p(pl)
    );

    ddio_mul #(.AW(M1W), .BW(17)) u_mul_right (
        .clk(clk), .rst_n(rst_n), .start(start2), .a(m1_p), .b(sum_r),
        .done(mr_done), .p(pr)
    );

    ddio_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
        .clk(clk), .rst_n(rst_n), .start(start2), .angle(mid32),
        .done(c_done), .cos_q(cos_q), .sin_q(sin_q)
    );

    ddio_mul #(.AW(ddio_pkg::CW_W), .BW(DW)) u_mul_x (
        .clk(clk), .rst_n(rst_n), .start(start3), .a(cos_q), .b(d),
        .done(mx_done), .p(px)
    );

    ddio_mul #(.AW(ddio_pkg::CW_W), .BW(DW)) u_mul_y (
        .clk(clk), .rst_n(rst_n), .start(start3), .a(sin_q), .b(d),
        .done(my_done), .p(py)
    );

    // sequencer: next state and unit starts
    always_comb
    begin
        state_next = state_reg;
        start1     = 1'b0;
        start2     = 1'b0;
        start3     = 1'b0;
        first_done = 1'b0;
        commit     = 1'b0;
        case (state_reg)
            ddio_pkg::ST_IDLE:
            begin
                if (frame.valid)
                begin
                    start1     = 1'b1;
                    state_next = ddio_pkg::ST_YAW;
                end
            end
            ddio_pkg::ST_YAW:
            begin
                if (div_done)
                begin
                    if (first_reg)
                    begin
                        first_done = 1'b1;
                        state_next = ddio_pkg::ST_IDLE;
                    end
                    else
                    begin
                        start2     = 1'b1;
                        state_next = ddio_pkg::ST_ROT;
                    end
                end
            end
            ddio_pkg::ST_ROT:
            begin
                if ((c_seen_reg || c_done) && (m_seen_reg || ml_done))
                begin
                    start3     = 1'b1;
                    state_next = ddio_pkg::ST_POS;
                end
            end
            ddio_pkg::ST_POS:
            begin
                if (mx_done)
                    state_next = ddio_pkg::ST_WB;
            end
            ddio_pkg::ST_WB:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    commit     = 1'b1;
                    state_next = ddio_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ddio_pkg::ST_IDLE;
            end
        endcase
    end

    // control and odometry state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ddio_pkg::ST_IDLE;
            first_reg     <= 1'b1;
            dpc_reg       <= ddio_pkg::DPC_RESET;
            last_l_reg    <= '0;
            last_r_reg    <= '0;
            last_yaw_reg  <= '0;
            heading_reg   <= ANGLE_BITS'(1) << (ANGLE_BITS - 2);
            left_acc_reg  <= '0;
            right_acc_reg <= '0;
            x_acc_reg     <= '0;
            y_acc_reg     <= '0;
            c_seen_reg    <= 1'b0;
            m_seen_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                dpc_reg <= cfg_wdata;
            // completion flags for the parallel phase
            if (start2)
            begin
                c_seen_reg <= 1'b0;
                m_seen_reg <= 1'b0;
            end
            else
            begin
                if (c_done)
                    c_seen_reg <= 1'b1;
                if (ml_done)
                    m_seen_reg <= 1'b1;
            end
            if (first_done)
            begin
                first_reg     <= 1'b0;
                last_l_reg    <= lr_reg;
                last_r_reg    <= rr_reg;
                last_yaw_reg  <= yaw_div;
                left_acc_reg  <= '0;
                right_acc_reg <= '0;
                x_acc_reg     <= '0;
                y_acc_reg     <= '0;
            end
            if (commit)
            begin
                last_l_reg    <= lr_reg;
                last_r_reg    <= rr_reg;
                last_yaw_reg  <= yaw_div;
                heading_reg   <= heading_new;
                left_acc_reg  <= left_new;
                right_acc_reg <= right_new;
                x_acc_reg     <= x_new;
                y_acc_reg     <= y_new;
            end
            // output register handshake
            if (commit)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lr_reg <= frame.left_rate;
            rr_reg <= frame.right_rate;
        end
        if (commit)
        begin
            o_ld_reg  <= ext_l[47:0];
            o_rd_reg  <= ext_r[47:0];
            o_x_reg   <= ext_x[47:0];
            o_y_reg   <= ext_y[47:0];
            o_ls_reg  <= lr_reg;
            o_rs_reg  <= rr_reg;
            o_hd_reg  <= hd32[31:16];
            o_yaw_reg <= yaw32[31:16];
        end
    end

    assign frame.ready           = state_reg == ddio_pkg::ST_IDLE;
    assign result.valid          = out_valid_reg;
    assign result.left_distance  = o_ld_reg;
    assign result.right_distance = o_rd_reg;
    assign result.left_speed     = o_ls_reg;
    assign result.right_speed    = o_rs_reg;
    assign result.x_position     = o_x_reg;
    assign result.y_position     = o_y_reg;
    assign result.heading        = o_hd_reg;
    assign result.yaw_angle      = o_yaw_reg;

    // right and y units run in step with their partners; the tick unit runs beside the divider
    logic unused_done;
    assign unused_done = m1_done ^ mr_done ^ my_done;
endmodule

// File: design/ddio_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the odometry top level, bound to every instance.
// Depends on ddio_ifs and diff_drive_imu_odometry_top_assert.svh.
`include "diff_drive_imu_odometry_top_assert.svh"

module ddio_checker (
    input logic           clk,
    input logic           rst_n,
    ddio_frame_if.sink    frame,
    ddio_result_if.source result
);
    // a stalled result stays offered
    `DDIO_ASSERT_NEXT(a_result_hold, result.valid && !result.ready, result.valid)
    // the block takes one item at a time
    `DDIO_ASSERT_NEXT(a_busy_after_take, frame.valid && frame.ready, !frame.ready)
    // no result can appear right after an item is taken
    `DDIO_ASSERT_NEXT(a_no_instant_result, frame.valid && frame.ready, !$rose(result.valid))
    // a fresh result leaves the block idle
    `DDIO_ASSERT_NOW(a_idle_on_result, $rose(result.valid), frame.ready)
endmodule

bind diff_drive_imu_odometry_top ddio_checker u_ddio_checker (
    .clk(clk),
    .rst_n(rst_n),
    .frame(frame),
    .result(result)
);
